>>> rtl/qtrs_pkg.sv
package qtrs_pkg;

    // reduced quaternion component magnitude, at most 2^15
    localparam int RED_BITS   = 16;
    localparam int RED_LIMIT  = 32768;
    localparam int COMPS      = 4;
    localparam int TERMS      = 9;
    // |a|*|b| of reduced components is at most 2^30
    localparam int PROD_BITS  = 31;
    // sum of four squares is at most 2^32
    localparam int LEN_BITS   = 33;
    // rotation product terms reach 2^31, so 32 quotient bits
    localparam int QUO_BITS   = 32;
    localparam int DIV_STEPS  = QUO_BITS;
    localparam int NUM_BITS   = 63;
    localparam int ROT_FRAC   = 30;
    localparam int DATA_BITS  = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    // component slots
    localparam int C_X = 0;
    localparam int C_Y = 1;
    localparam int C_Z = 2;
    localparam int C_W = 3;

    // product term slots
    localparam int T_XX = 0;
    localparam int T_YY = 1;
    localparam int T_ZZ = 2;
    localparam int T_XY = 3;
    localparam int T_XZ = 4;
    localparam int T_YZ = 5;
    localparam int T_WX = 6;
    localparam int T_WY = 7;
    localparam int T_WZ = 8;

    // one classified request, passed from front to back through the queue
    typedef struct packed {
        logic [2:0][DATA_BITS-1:0]     pos;
        logic [2:0][DATA_BITS-1:0]     scale;
        logic [TERMS-1:0][PROD_BITS-1:0] prod;
        logic [TERMS-1:0]              neg;
        logic [LEN_BITS-1:0]           len;
    } qtrs_item_t;

endpackage

>>> rtl/quaternion_trs_matrix_build.sv
// quaternion TRS matrix builder
//
// input channel (in_valid / in_stall): one request carries a Q16.16 position,
// a raw quaternion of QUAT_BITS-bit components and a Q16.16 per-axis scale
// output channel (out_valid / out_stall): the top three rows of the
// translate * rotate * scale matrix, twelve Q16.16 words, saturated
// - front: registers the request, reduces the quaternion components, forms
//   the nine pairwise products and the squared length
// - a four-entry queue decouples front and back
// - back: nine 32-stage bit-per-cycle dividers normalize the products, then
//   rotation assembly, scale multiply and round/saturate stages
// throughput: one request per cycle while out_stall is low, independent of the data
// path from accept to out_valid: front register, queue, divider input register,
// the 32-stage divider pipeline, then the rotation, multiply and output registers
// an all-zero quaternion gives the identity rotation
// reset clears every valid bit and the queue; payload regs are not reset
// out_stall while out_valid is high freezes the whole back pipeline; the queue then fills and
// in_stall rises once the queue and the front stage are full
module quaternion_trs_matrix_build
    import qtrs_pkg::*;
#(
    parameter int QUAT_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [31:0]           pos_x,
    input  logic signed [31:0]           pos_y,
    input  logic signed [31:0]           pos_z,
    input  logic signed [QUAT_BITS-1:0]  quat_x,
    input  logic signed [QUAT_BITS-1:0]  quat_y,
    input  logic signed [QUAT_BITS-1:0]  quat_z,
    input  logic signed [QUAT_BITS-1:0]  quat_w,
    input  logic signed [31:0]           scale_x,
    input  logic signed [31:0]           scale_y,
    input  logic signed [31:0]           scale_z,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [31:0]           row0_col0,
    output logic signed [31:0]           row0_col1,
    output logic signed [31:0]           row0_col2,
    output logic signed [31:0]           row0_col3,
    output logic signed [31:0]           row1_col0,
    output logic signed [31:0]           row1_col1,
    output logic signed [31:0]           row1_col2,
    output logic signed [31:0]           row1_col3,
    output logic signed [31:0]           row2_col0,
    output logic signed [31:0]           row2_col1,
    output logic signed [31:0]           row2_col2,
    output logic signed [31:0]           row2_col3
);

    logic [2:0][DATA_BITS-1:0]        pos_vec;
    logic [2:0][DATA_BITS-1:0]        scale_vec;
    logic [COMPS-1:0][QUAT_BITS-1:0]  quat_vec;

    // front to queue
    logic        push;
    qtrs_item_t  push_item;
    logic        fifo_full;

    // queue to back
    logic        pop;
    qtrs_item_t  head;
    logic        not_empty;

    logic [2:0][3:0][DATA_BITS-1:0]   mat;

    assign pos_vec   = {pos_z, pos_y, pos_x};
    assign scale_vec = {scale_z, scale_y, scale_x};
    assign quat_vec  = {quat_w, quat_z, quat_y, quat_x};

    qtrs_front #(
        .QUAT_BITS (QUAT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pos       (pos_vec),
        .quat      (quat_vec),
        .scale     (scale_vec),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    qtrs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    qtrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mat       (mat)
    );

    // row-major result words
    assign row0_col0 = mat[0][0];
    assign row0_col1 = mat[0][1];
    assign row0_col2 = mat[0][2];
    assign row0_col3 = mat[0][3];
    assign row1_col0 = mat[1][0];
    assign row1_col1 = mat[1][1];
    assign row1_col2 = mat[1][2];
    assign row1_col3 = mat[1][3];
    assign row2_col0 = mat[2][0];
    assign row2_col1 = mat[2][1];
    assign row2_col2 = mat[2][2];
    assign row2_col3 = mat[2][3];

endmodule

>>> rtl/qtrs_front.sv
module qtrs_front
    import qtrs_pkg::*;
#(
    parameter int QUAT_BITS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0][DATA_BITS-1:0]          pos,
    input  logic [COMPS-1:0][QUAT_BITS-1:0]    quat,
    input  logic [2:0][DATA_BITS-1:0]          scale,
    input  logic                               fifo_full,
    output logic                               push,
    output qtrs_item_t                         push_item
);

    localparam int MW     = (QUAT_BITS > RED_BITS) ? QUAT_BITS : RED_BITS;
    localparam int SH_MAX = (QUAT_BITS > RED_BITS) ? QUAT_BITS - RED_BITS : 0;
    localparam int SHW    = (SH_MAX > 0) ? $clog2(SH_MAX + 1) : 1;

    logic [COMPS-1:0][MW-1:0]        mag_ext;
    logic [COMPS-1:0]                qneg;
    logic [SHW-1:0]                  sh;
    logic [COMPS-1:0][RED_BITS-1:0]  red;

    logic                            f1_valid_reg;
    logic [COMPS-1:0][RED_BITS-1:0]  red_reg;
    logic [COMPS-1:0]                qneg_reg;
    logic [2:0][DATA_BITS-1:0]       pos_reg;
    logic [2:0][DATA_BITS-1:0]       scale_reg;
    logic                            advance;

    // magnitudes and signs of the raw components
    always_comb
    begin
        for (int i = 0; i < COMPS; i++)
        begin
            qneg[i]    = quat[i][QUAT_BITS-1];
            mag_ext[i] = MW'(qneg[i] ? QUAT_BITS'(-quat[i]) : quat[i]);
        end
    end

    // smallest shift bringing every magnitude to 2^15 or below
    always_comb
    begin
        logic ok;
        sh = '0;
        ok = 1'b1;
        for (int s = SH_MAX; s >= 0; s--)
        begin
            ok = 1'b1;
            for (int i = 0; i < COMPS; i++)
            begin
                if ((MW+1)'(mag_ext[i] >> s) > (MW+1)'(RED_LIMIT))
                begin
                    ok = 1'b0;
                end
            end
            if (ok)
            begin
                sh = SHW'(s);
            end
        end
        for (int i = 0; i < COMPS; i++)
        begin
            red[i] = RED_BITS'(mag_ext[i] >> sh);
        end
    end

    assign advance  = !f1_valid_reg || !fifo_full;
    assign in_stall = f1_valid_reg && fifo_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            f1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            red_reg   <= red;
            qneg_reg  <= qneg;
            pos_reg   <= pos;
            scale_reg <= scale;
        end
    end

    function automatic logic [PROD_BITS-1:0] pmul(input logic [RED_BITS-1:0] a,
                                                  input logic [RED_BITS-1:0] b);
        logic [2*RED_BITS-1:0] p;
        p = a * b;
        return PROD_BITS'(p);
    endfunction

    // pairwise products and squared length
    always_comb
    begin
        push_item.pos   = pos_reg;
        push_item.scale = scale_reg;

        push_item.prod[T_XX] = pmul(red_reg[C_X], red_reg[C_X]);
        push_item.prod[T_YY] = pmul(red_reg[C_Y], red_reg[C_Y]);
        push_item.prod[T_ZZ] = pmul(red_reg[C_Z], red_reg[C_Z]);
        push_item.prod[T_XY] = pmul(red_reg[C_X], red_reg[C_Y]);
        push_item.prod[T_XZ] = pmul(red_reg[C_X], red_reg[C_Z]);
        push_item.prod[T_YZ] = pmul(red_reg[C_Y], red_reg[C_Z]);
        push_item.prod[T_WX] = pmul(red_reg[C_W], red_reg[C_X]);
        push_item.prod[T_WY] = pmul(red_reg[C_W], red_reg[C_Y]);
        push_item.prod[T_WZ] = pmul(red_reg[C_W], red_reg[C_Z]);

        push_item.neg[T_XX] = 1'b0;
        push_item.neg[T_YY] = 1'b0;
        push_item.neg[T_ZZ] = 1'b0;
        push_item.neg[T_XY] = qneg_reg[C_X] ^ qneg_reg[C_Y];
        push_item.neg[T_XZ] = qneg_reg[C_X] ^ qneg_reg[C_Z];
        push_item.neg[T_YZ] = qneg_reg[C_Y] ^ qneg_reg[C_Z];
        push_item.neg[T_WX] = qneg_reg[C_W] ^ qneg_reg[C_X];
        push_item.neg[T_WY] = qneg_reg[C_W] ^ qneg_reg[C_Y];
        push_item.neg[T_WZ] = qneg_reg[C_W] ^ qneg_reg[C_Z];

        push_item.len = LEN_BITS'(pmul(red_reg[C_W], red_reg[C_W]))
                      + LEN_BITS'(push_item.prod[T_XX])
                      + LEN_BITS'(push_item.prod[T_YY])
                      + LEN_BITS'(push_item.prod[T_ZZ]);
    end

    assign push = f1_valid_reg && !fifo_full;

endmodule

>>> rtl/qtrs_fifo.sv
module qtrs_fifo
    import qtrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  qtrs_item_t push_item,
    output logic       full,
    input  logic       pop,
    output qtrs_item_t head,
    output logic       not_empty
);

    qtrs_item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W:0]     count_reg;
    logic [FIFO_PTR_W:0]     count_next;

    assign full      = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/qtrs_div.sv
module qtrs_div
    import qtrs_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [NUM_BITS-1:0]  num,
    input  logic [LEN_BITS-1:0]  den,
    output logic [QUO_BITS-1:0]  quo
);

    // one quotient bit per stage; the top numerator bits seed the remainder

    logic [LEN_BITS-1:0]  rem_reg  [DIV_STEPS];
    logic [QUO_BITS-1:0]  low_reg  [DIV_STEPS];
    logic [QUO_BITS-1:0]  quo_reg  [DIV_STEPS];
    logic [LEN_BITS-1:0]  den_reg  [DIV_STEPS];

    logic [LEN_BITS-1:0]  rem_next [DIV_STEPS];
    logic [QUO_BITS-1:0]  low_next [DIV_STEPS];
    logic [QUO_BITS-1:0]  quo_next [DIV_STEPS];
    logic [LEN_BITS-1:0]  den_next [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            logic [LEN_BITS-1:0] rem_in;
            logic [QUO_BITS-1:0] low_in;
            logic [QUO_BITS-1:0] quo_in;
            logic [LEN_BITS-1:0] den_in;
            logic [LEN_BITS:0]   trial;
            logic                ge;

            if (k == 0)
            begin : g_first
                assign rem_in = LEN_BITS'(num[NUM_BITS-1:DIV_STEPS]);
                assign low_in = num[DIV_STEPS-1:0];
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign low_in = low_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            assign trial       = {rem_in, low_in[QUO_BITS-1]};
            assign ge          = (trial >= {1'b0, den_in});
            assign rem_next[k] = ge ? LEN_BITS'(trial - {1'b0, den_in}) : LEN_BITS'(trial);
            assign low_next[k] = {low_in[QUO_BITS-2:0], 1'b0};
            assign quo_next[k] = {quo_in[QUO_BITS-2:0], ge};
            assign den_next[k] = den_in;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next[k];
                    low_reg[k] <= low_next[k];
                    quo_reg[k] <= quo_next[k];
                    den_reg[k] <= den_next[k];
                end
            end
        end
    endgenerate

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

>>> rtl/qtrs_back.sv
module qtrs_back
    import qtrs_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  qtrs_item_t                         head,
    input  logic                               not_empty,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2:0][3:0][DATA_BITS-1:0]     mat
);

    typedef struct packed {
        logic [2:0][DATA_BITS-1:0] pos;
        logic [2:0][DATA_BITS-1:0] scale;
        logic [TERMS-1:0]          neg;
        logic                      len_zero;
    } qtrs_side_t;

    localparam int TERM_W = QUO_BITS + 2;
    localparam int ROT_W  = QUO_BITS + 3;
    localparam int MUL_W  = 2 * DATA_BITS;
    localparam int RND_W  = MUL_W - ROT_FRAC;

    logic                 en;

    logic                 b0_valid_reg;
    qtrs_item_t           b0_item_reg;

    logic [QUO_BITS-1:0]  quo [TERMS];
    qtrs_side_t           side_reg  [DIV_STEPS];
    logic                 vld_reg   [DIV_STEPS];

    logic signed [TERM_W-1:0]  term [TERMS];
    logic signed [ROT_W-1:0]   rot  [3][3];

    logic                            m1_valid_reg;
    logic [2:0][2:0][DATA_BITS-1:0]  m1_rmag_reg;
    logic [2:0][2:0]                 m1_rneg_reg;
    logic [2:0][DATA_BITS-1:0]       m1_smag_reg;
    logic [2:0]                      m1_sneg_reg;
    logic [2:0][DATA_BITS-1:0]       m1_pos_reg;

    logic                            m2_valid_reg;
    logic [2:0][2:0][MUL_W-1:0]      m2_prod_reg;
    logic [2:0][2:0]                 m2_neg_reg;
    logic [2:0][DATA_BITS-1:0]       m2_pos_reg;

    logic                            out_valid_reg;
    logic [2:0][3:0][DATA_BITS-1:0]  out_reg;
    logic [2:0][3:0][DATA_BITS-1:0]  out_next;

    assign en  = !out_valid_reg || !out_stall;
    assign pop = en && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b0_valid_reg <= not_empty;
            vld_reg[0]   <= b0_valid_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            m1_valid_reg  <= vld_reg[DIV_STEPS-1];
            m2_valid_reg  <= m1_valid_reg;
            out_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_item_reg <= head;
        end
    end

    // nine dividers: (2ab*2^30 + len/2) / len
    genvar t;
    generate
        for (t = 0; t < TERMS; t++)
        begin : g_term
            logic [NUM_BITS-1:0] num;
            assign num = NUM_BITS'({b0_item_reg.prod[t], 31'b0})
                       + NUM_BITS'(b0_item_reg.len >> 1);
            qtrs_div u_div (
                .clk (clk),
                .en  (en),
                .num (num),
                .den (b0_item_reg.len),
                .quo (quo[t])
            );
        end
    endgenerate

    // sideband follows the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].pos      <= b0_item_reg.pos;
            side_reg[0].scale    <= b0_item_reg.scale;
            side_reg[0].neg      <= b0_item_reg.neg;
            side_reg[0].len_zero <= (b0_item_reg.len == '0);
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // signed terms and rotation
    always_comb
    begin
        qtrs_side_t sd;
        sd = side_reg[DIV_STEPS-1];
        for (int i = 0; i < TERMS; i++)
        begin
            if (sd.len_zero)
            begin
                term[i] = '0;
            end
            else if (sd.neg[i])
            begin
                term[i] = -$signed(TERM_W'(quo[i]));
            end
            else
            begin
                term[i] = $signed(TERM_W'(quo[i]));
            end
        end
        rot[0][0] = (ROT_W'(1) <<< ROT_FRAC) - (ROT_W'(term[T_YY]) + ROT_W'(term[T_ZZ]));
        rot[0][1] = ROT_W'(term[T_XY]) - ROT_W'(term[T_WZ]);
        rot[0][2] = ROT_W'(term[T_XZ]) + ROT_W'(term[T_WY]);
        rot[1][0] = ROT_W'(term[T_XY]) + ROT_W'(term[T_WZ]);
        rot[1][1] = (ROT_W'(1) <<< ROT_FRAC) - (ROT_W'(term[T_XX]) + ROT_W'(term[T_ZZ]));
        rot[1][2] = ROT_W'(term[T_YZ]) - ROT_W'(term[T_WX]);
        rot[2][0] = ROT_W'(term[T_XZ]) - ROT_W'(term[T_WY]);
        rot[2][1] = ROT_W'(term[T_YZ]) + ROT_W'(term[T_WX]);
        rot[2][2] = (ROT_W'(1) <<< ROT_FRAC) - (ROT_W'(term[T_XX]) + ROT_W'(term[T_YY]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    m1_rneg_reg[i][j] <= rot[i][j][ROT_W-1];
                    m1_rmag_reg[i][j] <= rot[i][j][ROT_W-1] ? DATA_BITS'(-rot[i][j])
                                                            : DATA_BITS'(rot[i][j]);
                end
                m1_sneg_reg[i] <= side_reg[DIV_STEPS-1].scale[i][DATA_BITS-1];
                m1_smag_reg[i] <= side_reg[DIV_STEPS-1].scale[i][DATA_BITS-1]
                                ? DATA_BITS'(-side_reg[DIV_STEPS-1].scale[i])
                                : side_reg[DIV_STEPS-1].scale[i];
                m1_pos_reg[i]  <= side_reg[DIV_STEPS-1].pos[i];
            end
        end
    end

    // column j of the rotation times scale j
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    m2_prod_reg[i][j] <= MUL_W'(m1_rmag_reg[i][j]) * MUL_W'(m1_smag_reg[j]);
                    m2_neg_reg[i][j]  <= m1_rneg_reg[i][j] ^ m1_sneg_reg[j];
                end
            end
            m2_pos_reg <= m1_pos_reg;
        end
    end

    // round half away from zero, saturate
    always_comb
    begin
        logic [RND_W-1:0] res;
        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                res = RND_W'((m2_prod_reg[i][j] + (MUL_W'(1) << (ROT_FRAC - 1))) >> ROT_FRAC);
                if (m2_neg_reg[i][j])
                begin
                    if (res >= (RND_W'(1) << (DATA_BITS - 1)))
                    begin
                        out_next[i][j] = {1'b1, {(DATA_BITS-1){1'b0}}};
                    end
                    else
                    begin
                        out_next[i][j] = DATA_BITS'(-res);
                    end
                end
                else
                begin
                    if (res > RND_W'({1'b0, {(DATA_BITS-1){1'b1}}}))
                    begin
                        out_next[i][j] = {1'b0, {(DATA_BITS-1){1'b1}}};
                    end
                    else
                    begin
                        out_next[i][j] = DATA_BITS'(res);
                    end
                end
            end
            out_next[i][3] = m2_pos_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign mat       = out_reg;

endmodule

>>> test/quaternion_trs_matrix_build_test.sv
`timescale 1ns / 100ps

module quaternion_trs_matrix_build_test;

    // one transform request and the matrix it should produce
    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [15:0] quat [4];   // x, y, z, w
        logic signed [31:0] scl [3];
    } trs_request_t;

    typedef struct {
        logic signed [31:0] cell_val [3][4];
    } trs_matrix_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    logic signed [31:0] scale_x, scale_y, scale_z;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] row0_col0, row0_col1, row0_col2, row0_col3;
    logic signed [31:0] row1_col0, row1_col1, row1_col2, row1_col3;
    logic signed [31:0] row2_col0, row2_col1, row2_col2, row2_col3;

    trs_matrix_t matrix_queue[$];
    int error_count = 0;

    // extra wait after the last expected matrix has been checked
    localparam int DRAIN_CYCLES = 80;

    quaternion_trs_matrix_build i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .scale_x   (scale_x),
        .scale_y   (scale_y),
        .scale_z   (scale_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row0_col0 (row0_col0),
        .row0_col1 (row0_col1),
        .row0_col2 (row0_col2),
        .row0_col3 (row0_col3),
        .row1_col0 (row1_col0),
        .row1_col1 (row1_col1),
        .row1_col2 (row1_col2),
        .row1_col3 (row1_col3),
        .row2_col0 (row2_col0),
        .row2_col1 (row2_col1),
        .row2_col2 (row2_col2),
        .row2_col3 (row2_col3)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // 2*a*b/len in Q2.30, rounded half away from zero
    function automatic longint norm_product(longint a, longint b, longint len);
        longint unsigned p;
        longint unsigned q;
        if (len == 0)
            return 0;
        p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
        q = ((p << 31) + (len >> 1)) / len;
        return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // Q2.30 rotation element times Q16.16 scale, rounded and saturated
    function automatic logic signed [31:0] scaled_element(longint r, longint s);
        longint unsigned res;
        res = ((r < 0 ? -r : r) * (s < 0 ? -s : s) + (64'd1 << 29)) >> 30;
        if ((r < 0) != (s < 0))
            return (res >= (64'd1 << 31)) ? 32'sh8000_0000 : 32'(-longint'(res));
        return (res > 64'h7fff_ffff) ? 32'sh7fff_ffff : 32'(res);
    endfunction

    function automatic trs_matrix_t predict_matrix(trs_request_t req);
        trs_matrix_t m;
        longint qc [4];
        longint len;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint rot [3][3];
        longint one;
        one = 64'sd1 << 30;
        len = 0;
        // 16-bit components never exceed 2^15, so no reduction shift applies
        for (int i = 0; i < 4; i++)
        begin
            qc[i] = req.quat[i];
            len += qc[i] * qc[i];
        end
        xx = norm_product(qc[0], qc[0], len);
        yy = norm_product(qc[1], qc[1], len);
        zz = norm_product(qc[2], qc[2], len);
        xy = norm_product(qc[0], qc[1], len);
        xz = norm_product(qc[0], qc[2], len);
        yz = norm_product(qc[1], qc[2], len);
        wx = norm_product(qc[3], qc[0], len);
        wy = norm_product(qc[3], qc[1], len);
        wz = norm_product(qc[3], qc[2], len);
        rot[0][0] = one - (yy + zz);
        rot[0][1] = xy - wz;
        rot[0][2] = xz + wy;
        rot[1][0] = xy + wz;
        rot[1][1] = one - (xx + zz);
        rot[1][2] = yz - wx;
        rot[2][0] = xz - wy;
        rot[2][1] = yz + wx;
        rot[2][2] = one - (xx + yy);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                m.cell_val[i][j] = scaled_element(rot[i][j], req.scl[j]);
            m.cell_val[i][3] = req.pos[i];
        end
        return m;
    endfunction

    // drive one request after a random gap and hold it until accepted
    task automatic send_request(trs_request_t req);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x    <= req.pos[0];
        pos_y    <= req.pos[1];
        pos_z    <= req.pos[2];
        quat_x   <= req.quat[0];
        quat_y   <= req.quat[1];
        quat_z   <= req.quat[2];
        quat_w   <= req.quat[3];
        scale_x  <= req.scl[0];
        scale_y  <= req.scl[1];
        scale_z  <= req.scl[2];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge; expectation goes in before the result can appear
        matrix_queue.push_back(predict_matrix(req));
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 131072)) - 65536);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic trs_request_t make_request(logic [15:0] qx, logic [15:0] qy,
        logic [15:0] qz, logic [15:0] qw, logic [31:0] s, logic [31:0] p);
        trs_request_t req;
        req.quat[0] = qx;
        req.quat[1] = qy;
        req.quat[2] = qz;
        req.quat[3] = qw;
        for (int i = 0; i < 3; i++)
        begin
            req.scl[i] = s;
            req.pos[i] = p;
        end
        return req;
    endfunction

    // identity, axis rotations, zero quaternion, extremes, saturation
    task automatic test_directed();
        send_request(make_request(16'h0000, 16'h0000, 16'h0000, 16'h0000,
            32'h0001_0000, 32'h0000_0000));
        send_request(make_request(16'h0000, 16'h0000, 16'h0000, 16'h0000,
            32'h7fff_ffff, 32'h7fff_ffff));
        send_request(make_request(16'h0000, 16'h0000, 16'h0000, 16'h0001,
            32'h0001_0000, 32'h8000_0000));
        send_request(make_request(16'h7fff, 16'h0000, 16'h0000, 16'h0000,
            32'h0001_0000, 32'h1234_5678));
        send_request(make_request(16'h0000, 16'h8000, 16'h0000, 16'h0000,
            32'h0002_0000, 32'hffff_ffff));
        send_request(make_request(16'h0000, 16'h0000, 16'h7fff, 16'h7fff,
            32'hffff_0000, 32'h0000_0001));
        send_request(make_request(16'h8000, 16'h8000, 16'h8000, 16'h8000,
            32'h7fff_ffff, 32'h8000_0000));
        send_request(make_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
            32'h8000_0000, 32'h7fff_ffff));
        send_request(make_request(16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
            32'h0000_0000, 32'h0000_0000));
        send_request(make_request(16'h0001, 16'h0000, 16'h0000, 16'h0001,
            32'h8000_0000, 32'h5555_aaaa));
        send_request(make_request(16'hffff, 16'h0001, 16'hffff, 16'h0000,
            32'h7fff_ffff, 32'haaaa_5555));
        send_request(make_request(16'h0000, 16'h0000, 16'h0001, 16'h0000,
            32'h8000_0001, 32'h0000_0000));
    endtask

    task automatic test_random(int count);
        trs_request_t req;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 4; i++)
                req.quat[i] = rand_comp();
            for (int i = 0; i < 3; i++)
            begin
                req.pos[i] = rand_word();
                req.scl[i] = rand_word();
            end
            send_request(req);
        end
    endtask

    // hold the sender off until the pipeline has drained completely, then send twenty random requests
    task automatic test_drain_pause();
        in_valid <= 1'b0;
        while (matrix_queue.size() != 0)
            @(posedge clk);
        test_random(20);
    endtask

    // result side: random stall per result, then compare with the oldest prediction
    initial
    begin
        trs_matrix_t exp_m;
        logic signed [31:0] got [3][4];
        int hold;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(0, 3);
            out_stall <= (hold != 0);
            repeat (hold) @(posedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got = '{'{row0_col0, row0_col1, row0_col2, row0_col3},
                    '{row1_col0, row1_col1, row1_col2, row1_col3},
                    '{row2_col0, row2_col1, row2_col2, row2_col3}};
            if (matrix_queue.size() == 0)
            begin
                $error("matrix with no request pending");
                error_count++;
            end
            else
            begin
                exp_m = matrix_queue.pop_front();
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 4; j++)
                        if (got[i][j] !== exp_m.cell_val[i][j])
                        begin
                            $error("row%0d_col%0d expected %h got %h", i, j,
                                exp_m.cell_val[i][j], got[i][j]);
                            error_count++;
                        end
            end
        end
    end

    // stimulus
    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        pos_x = '0; pos_y = '0; pos_z = '0;
        quat_x = '0; quat_y = '0; quat_z = '0; quat_w = '0;
        scale_x = '0; scale_y = '0; scale_z = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(850);
        test_drain_pause();
        test_random(870);
        in_valid <= 1'b0;
        while (matrix_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> quaternion_trs_matrix_build.f
rtl/qtrs_pkg.sv
rtl/qtrs_front.sv
rtl/qtrs_fifo.sv
rtl/qtrs_div.sv
rtl/qtrs_back.sv
rtl/quaternion_trs_matrix_build.sv
test/quaternion_trs_matrix_build_test.sv
